[rtl/pwm_input_period_duty_measure_defines.svh]
// Assertion macros shared by the PWM measurement RTL.
`ifndef PWM_INPUT_PERIOD_DUTY_MEASURE_DEFINES_SVH
`define PWM_INPUT_PERIOD_DUTY_MEASURE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PWMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pwmm_pkg.sv]
// Types and constants shared by the PWM measurement modules.
package pwmm_pkg;

  localparam int unsigned FREQ_W  = 20;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned WAIT_W  = 32;

  localparam logic [WAIT_W-1:0] TIMEOUT_RESET = 32'd1000000;
  localparam logic [FREQ_W-1:0] MICRO_PER_SEC = 20'd1000000;
  localparam logic [DUTY_W-1:0] PERCENT       = 7'd100;

  localparam logic MODE_ARM  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [STAT_W-1:0] ST_MEASURED = 2'd0;
  localparam logic [STAT_W-1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FAULT    = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  typedef struct packed {
    logic mode;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_hz;
    logic [DUTY_W-1:0] duty_percent;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE2 = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    JOB_MEAS    = 2'd0,
    JOB_TIMEOUT = 2'd1,
    JOB_FAULT   = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e kind;
    logic      pin;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_DONE = 2'd2
  } back_state_e;

endpackage

[rtl/pwmm_front.sv]
// Front end: accepts items, tracks edges and timestamps, queues finished jobs.
`include "pwm_input_period_duty_measure_defines.svh"

module pwmm_front #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  pwmm_pkg::in_item_t       in_item_i,
  input  logic [31:0]              timeout_i,
  input  logic                     q_full_i,
  output logic                     in_stall_o,
  output logic                     push_o,
  output pwmm_pkg::job_t           job_o,
  output logic [COUNT_WIDTH-1:0]   high_o,
  output logic [COUNT_WIDTH:0]     period_o
);
  import pwmm_pkg::*;

  logic                   armed_q, armed_d;
  phase_e                 phase_q, phase_d;
  logic                   prev_q, prev_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [COUNT_WIDTH-1:0] rise_q, rise_d;
  logic [COUNT_WIDTH-1:0] fall_q, fall_d;
  logic [WAIT_W-1:0]      wait_q, wait_d;

  logic                   accept;
  logic                   rise_edge, fall_edge, done;
  logic [COUNT_WIDTH-1:0] high, low;
  logic [COUNT_WIDTH:0]   period;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign rise_edge  = ~prev_q & in_item_i.pin_level;
  assign fall_edge  = prev_q & ~in_item_i.pin_level;

  // Each span wraps at the counter width; the sum keeps one more bit.
  assign high     = fall_q - rise_q;
  assign low      = tick_q - fall_q;
  assign period   = {1'b0, high} + {1'b0, low};
  assign high_o   = high;
  assign period_o = period;

  always_comb begin
    armed_d   = armed_q;
    phase_d   = phase_q;
    prev_d    = prev_q;
    tick_d    = tick_q;
    rise_d    = rise_q;
    fall_d    = fall_q;
    wait_d    = wait_q;
    done      = 1'b0;
    push_o    = 1'b0;
    job_o     = '{kind: JOB_MEAS, pin: in_item_i.pin_level};
    if (accept) begin
      prev_d = in_item_i.pin_level;
      if (in_item_i.mode == MODE_ARM) begin
        armed_d = 1'b1;
        phase_d = PH_RISE1;
        tick_d  = '0;
        wait_d  = '0;
      end else begin
        tick_d = tick_q + 1'b1;
        if (armed_q) begin
          case (phase_q)
            PH_RISE1: begin
              if (rise_edge) begin
                rise_d  = tick_q;
                phase_d = PH_FALL;
              end
            end
            PH_FALL: begin
              if (fall_edge) begin
                fall_d  = tick_q;
                phase_d = PH_RISE2;
              end
            end
            PH_RISE2: begin
              done = rise_edge;
            end
            default: begin
              phase_d = PH_RISE1;
            end
          endcase
          if (done) begin
            push_o     = 1'b1;
            job_o.kind = (period == '0) ? JOB_FAULT : JOB_MEAS;
            armed_d    = 1'b0;
            phase_d    = PH_RISE1;
          end else begin
            wait_d = wait_q + 1'b1;
            if (wait_d >= timeout_i) begin
              push_o     = 1'b1;
              job_o.kind = JOB_TIMEOUT;
              armed_d    = 1'b0;
              phase_d    = PH_RISE1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      phase_q <= PH_RISE1;
      prev_q  <= 1'b0;
      tick_q  <= '0;
      rise_q  <= '0;
      fall_q  <= '0;
      wait_q  <= '0;
    end else begin
      armed_q <= armed_d;
      phase_q <= phase_d;
      prev_q  <= prev_d;
      tick_q  <= tick_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      wait_q  <= wait_d;
    end
  end

  `PWMM_ASSERT_NOW(a_idle_phase, !armed_q, phase_q == PH_RISE1, "idle front with phase set")

endmodule

[rtl/pwmm_fifo.sv]
// Two-entry job queue between front end and divider back end.
`include "pwm_input_period_duty_measure_defines.svh"

module pwmm_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  import pwmm_pkg::*;

  logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end

  `PWMM_ASSERT_NOW(a_no_overflow, push_i, !full_o, "push into full queue")
  `PWMM_ASSERT_NOW(a_no_underflow, pop_i, !empty_o, "pop from empty queue")

endmodule

[rtl/pwmm_back.sv]
// Back end: serial divider for frequency and duty, plus the output register.
`include "pwm_input_period_duty_measure_defines.svh"

module pwmm_back #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  pwmm_pkg::job_t         job_i,
  input  logic [COUNT_WIDTH-1:0] high_i,
  input  logic [COUNT_WIDTH:0]   period_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output pwmm_pkg::out_item_t    out_item_o
);
  import pwmm_pkg::*;

  localparam int unsigned PW    = COUNT_WIDTH + 1;
  localparam int unsigned DW    = (COUNT_WIDTH + 7 >= 20) ? COUNT_WIDTH + 7 : 20;
  localparam int unsigned CNT_W = $clog2(DW);

  back_state_e state_q, state_d;

  job_kind_e        kind_q;
  logic             pin_q;
  logic [PW-1:0]    den_q;
  logic [DW-1:0]    num_f_q, num_d_q;
  logic [PW-1:0]    rem_f_q, rem_d_q;
  logic [CNT_W-1:0] cnt_q;

  logic             out_valid_q;
  out_item_t        out_item_q;
  out_item_t        res;

  logic             div_step, last_step, load_out;
  logic [PW:0]      sh_f, sh_d, dif_f, dif_d;
  logic             qb_f, qb_d;
  logic [DW-1:0]    scaled_high;

  // high * 100 as shifts and adds: 64 + 32 + 4.
  assign scaled_high = (DW'(high_i) << 6) + (DW'(high_i) << 5) + (DW'(high_i) << 2);

  // One restoring step per cycle on both quotients.
  assign sh_f  = {rem_f_q, num_f_q[DW-1]};
  assign sh_d  = {rem_d_q, num_d_q[DW-1]};
  assign dif_f = sh_f - {1'b0, den_q};
  assign dif_d = sh_d - {1'b0, den_q};
  assign qb_f  = (sh_f >= {1'b0, den_q});
  assign qb_d  = (sh_d >= {1'b0, den_q});

  assign last_step = (cnt_q == CNT_W'(DW - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = (job_i.kind == JOB_MEAS) ? BK_DIV : BK_DONE;
        end
      end
      BK_DIV: begin
        if (last_step) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o    = (state_q == BK_IDLE) && !q_empty_i;
    div_step = (state_q == BK_DIV);
    load_out = (state_q == BK_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    case (kind_q)
      JOB_MEAS: begin
        res = '{freq_hz: num_f_q[FREQ_W-1:0], duty_percent: num_d_q[DUTY_W-1:0],
                status: ST_MEASURED};
      end
      JOB_TIMEOUT: begin
        res = '{freq_hz: '0, duty_percent: (pin_q ? PERCENT : '0), status: ST_TIMEOUT};
      end
      default: begin
        res = '{freq_hz: '0, duty_percent: '0, status: ST_FAULT};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= job_i.kind;
      pin_q   <= job_i.pin;
      den_q   <= period_i;
      num_f_q <= DW'(MICRO_PER_SEC);
      num_d_q <= scaled_high;
      rem_f_q <= '0;
      rem_d_q <= '0;
      cnt_q   <= '0;
    end else if (div_step) begin
      rem_f_q <= qb_f ? dif_f[PW-1:0] : sh_f[PW-1:0];
      rem_d_q <= qb_d ? dif_d[PW-1:0] : sh_d[PW-1:0];
      num_f_q <= {num_f_q[DW-2:0], qb_f};
      num_d_q <= {num_d_q[DW-2:0], qb_d};
      cnt_q   <= cnt_q + 1'b1;
    end
    if (load_out) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `PWMM_ASSERT_NOW(a_div_nonzero, div_step, den_q != '0, "divide by zero period")
  `PWMM_ASSERT_NOW(a_duty_range, out_valid_q, out_item_q.duty_percent <= PERCENT, "duty above 100")

endmodule

[rtl/pwm_input_period_duty_measure.sv]
// PWM input period and duty measurement, top level.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_item_i): an item with mode 0
//    arms a measurement; mode 1 is one microsecond tick carrying the pin level.
//  - The front end timestamps rise, fall, rise with a wrapping COUNT_WIDTH
//    counter and queues a job when the closing rise or the timeout arrives.
//  - Output channel (out_valid_o / out_stall_i / out_item_o): one item per
//    finished measurement: frequency, duty percent and status.
//  - Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): timeout in ticks,
//    always ready; write it only while no measurement is in flight.
// Timing: the front end takes one input item per cycle while the queue is not
//  full. A measured result passes through DW = max(COUNT_WIDTH + 7, 20) steps
//  of the shared restoring divider, 23 at the default width, and the back end
//  takes its next job only after the previous result is loaded into the output
//  register; timeout and fault results skip the divider. A two-entry queue
//  decouples the halves.
// Reset: timeout returns to 1000000, the block is idle, the queue is empty.
// Stall: a stalled result holds in the output register; the divider finishes
//  the next job, then the queue fills and in_stall_o rises when it is full.
module pwm_input_period_duty_measure #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pwmm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pwmm_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);
  import pwmm_pkg::*;

  localparam int unsigned QW = JOB_W + COUNT_WIDTH + COUNT_WIDTH + 1;

  logic [WAIT_W-1:0]      timeout_q;

  logic                   push, pop, q_full, q_empty;
  job_t                   job_in, job_out;
  logic [COUNT_WIDTH-1:0] high_in, high_out;
  logic [COUNT_WIDTH:0]   period_in, period_out;
  logic [QW-1:0]          q_wdata, q_rdata;

  // Timeout register: writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  // Edge tracking and classification.
  pwmm_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .timeout_i (timeout_q),
    .q_full_i  (q_full),
    .in_stall_o(in_stall_o),
    .push_o    (push),
    .job_o     (job_in),
    .high_o    (high_in),
    .period_o  (period_in)
  );

  // Pack a job with its spans for the queue.
  assign q_wdata = {job_in, high_in, period_in};
  assign {job_out, high_out, period_out} = q_rdata;

  pwmm_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .pop_i  (pop),
    .data_o (q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // Divide and deliver.
  pwmm_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .job_i      (job_out),
    .high_i     (high_out),
    .period_i   (period_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

[tb/sv/pwm_input_period_duty_measure_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the PWM period and duty measurement block.
module pwm_input_period_duty_measure_tb;
  import pwmm_pkg::*;

  localparam int unsigned CNT_W         = 16;
  localparam int unsigned SETTLE_CYCLES = 64;   // pause after everything drains
  localparam int unsigned HOLD_CYCLES   = 400;  // one long receiver hold-off
  localparam int unsigned QUIET_LIMIT   = 4000; // cycles with no handshake at all

  // Clock, reset and block ports; every input starts at a known value.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;

  // Stimulus waiting to be offered, and readings the block still owes us.
  in_item_t  pin_samples_q[$];
  out_item_t readings_due[$];

  // Shadow of the measurement state, kept in step with accepted items.
  logic [31:0]      pw_timeout    = TIMEOUT_RESET;
  phase_e           pw_phase      = PH_RISE1;
  logic             pw_armed      = 1'b0;
  logic             pw_prev_pin   = 1'b0;
  logic [CNT_W-1:0] pw_tick       = '0;
  logic [CNT_W-1:0] pw_first_rise = '0;
  logic [CNT_W-1:0] pw_fall_at    = '0;
  logic [31:0]      pw_wait       = '0;

  // Idling control: idle_en is dropped for the last part of the run, the
  // calm flags give stretches without gaps on each side.
  logic        idle_en   = 1'b1;
  logic        snd_calm  = 1'b0;
  logic        rcv_calm  = 1'b0;
  int unsigned snd_gap   = 0;
  int unsigned rcv_gap   = 0;
  logic        hold_arm  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned n_gen       = 0;
  int unsigned n_items     = 0;
  int unsigned n_measured  = 0;
  int unsigned n_timeout   = 0;
  int unsigned n_fault     = 0;
  int unsigned n_mismatch  = 0;
  int unsigned n_in_stall  = 0;
  int unsigned quiet       = 0;

  pwm_input_period_duty_measure #(
    .COUNT_WIDTH (CNT_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Advance the shadow state by one accepted item and queue the reading it
  // produces, if any. Edges are judged against the previous pin level, and
  // an edge captures the tick count from before this tick's increment.
  task automatic predict_reading(input in_item_t s);
    logic             rise;
    logic             fall;
    logic             third;
    logic [CNT_W-1:0] stamp;
    logic [CNT_W-1:0] hi_w;
    logic [CNT_W-1:0] lo_w;
    int unsigned      high;
    int unsigned      period;
    int unsigned      freq;
    int unsigned      duty;
    out_item_t        r;
    rise  = !pw_prev_pin && s.pin_level;
    fall  = pw_prev_pin && !s.pin_level;
    stamp = pw_tick;
    third = 1'b0;
    pw_prev_pin = s.pin_level;
    if (s.mode == MODE_ARM) begin
      // Arm or restart: a pin already high does not count as a rise.
      pw_armed = 1'b1;
      pw_phase = PH_RISE1;
      pw_tick  = '0;
      pw_wait  = '0;
    end else begin
      pw_tick = pw_tick + 1'b1;
      if (pw_armed) begin
        case (pw_phase)
          PH_RISE1: if (rise) begin
            pw_first_rise = stamp;
            pw_phase      = PH_FALL;
          end
          PH_FALL: if (fall) begin
            pw_fall_at = stamp;
            pw_phase   = PH_RISE2;
          end
          default: third = rise;
        endcase
        if (third) begin
          // High and low wrap separately, the sum is taken at full width.
          hi_w   = pw_fall_at - pw_first_rise;
          lo_w   = stamp - pw_fall_at;
          high   = hi_w;
          period = high + lo_w;
          pw_armed = 1'b0;
          pw_phase = PH_RISE1;
          r = '0;
          if (period == 0) begin
            r.status = ST_FAULT;
          end else begin
            freq           = MICRO_PER_SEC / period;
            duty           = (high * PERCENT) / period;
            r.freq_hz      = freq[FREQ_W-1:0];
            r.duty_percent = duty[DUTY_W-1:0];
            r.status       = ST_MEASURED;
          end
          readings_due.push_back(r);
        end else begin
          pw_wait = pw_wait + 1;
          if (pw_wait >= pw_timeout) begin
            pw_armed       = 1'b0;
            pw_phase       = PH_RISE1;
            r              = '0;
            r.duty_percent = s.pin_level ? PERCENT : '0;
            r.status       = ST_TIMEOUT;
            readings_due.push_back(r);
          end
        end
      end
    end
  endtask

  // Sender: offer queued items, hold a stalled one, insert idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      snd_gap    <= 0;
    end else begin
      if (in_valid_i && in_stall_o) begin
        n_in_stall++;
      end
      if (in_valid_i && !in_stall_o) begin
        predict_reading(in_item_i);
        n_items++;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled item as it is
      end else if (snd_gap != 0) begin
        in_valid_i <= 1'b0;
        snd_gap    <= snd_gap - 1;
      end else if (idle_en && !snd_calm && $urandom_range(0, 9) == 0) begin
        in_valid_i <= 1'b0;
        snd_gap    <= $urandom_range(0, 13);
      end else if (pin_samples_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pin_samples_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
      if ($urandom_range(0, 199) == 0) begin
        snd_calm <= !snd_calm;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off that lets the
  // block back up until it stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rcv_gap     <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
        out_stall_i <= 1'b1;
        hold_left   <= HOLD_CYCLES - 1;
        hold_done   <= 1'b1;
      end else if (rcv_gap != 0) begin
        out_stall_i <= 1'b1;
        rcv_gap     <= rcv_gap - 1;
      end else if (idle_en && !rcv_calm && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        rcv_gap     <= $urandom_range(0, 13);
      end else begin
        out_stall_i <= 1'b0;
      end
      if ($urandom_range(0, 199) == 0) begin
        rcv_calm <= !rcv_calm;
      end
    end
  end

  // Compare each accepted reading with the oldest one owed.
  always @(posedge clk_i) begin : check_readings
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (readings_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("unexpected reading: freq %0d duty %0d status %0d",
                   out_item_o.freq_hz, out_item_o.duty_percent, out_item_o.status);
        end
      end else begin
        want = readings_due.pop_front();
        if (out_item_o.freq_hz !== want.freq_hz ||
            out_item_o.duty_percent !== want.duty_percent ||
            out_item_o.status !== want.status) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("reading mismatch: expected freq %0d duty %0d status %0d, got %0d %0d %0d",
                     want.freq_hz, want.duty_percent, want.status,
                     out_item_o.freq_hz, out_item_o.duty_percent, out_item_o.status);
          end
        end
      end
      case (out_item_o.status)
        ST_MEASURED: n_measured++;
        ST_TIMEOUT:  n_timeout++;
        default:     n_fault++;
      endcase
    end
  end

  // Watchdog: drop the run if no channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet == QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("pwm_input_period_duty_measure_tb NOT OK");
        $finish;
      end
    end
  end

  // Queue n copies of one item.
  task automatic offer(input logic m, input logic p, input int unsigned n);
    in_item_t s;
    s.mode      = m;
    s.pin_level = p;
    repeat (n) pin_samples_q.push_back(s);
    n_gen += n;
  endtask

  // Mostly short pulses, now and then a long one.
  function automatic int unsigned pulse_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12);
  endfunction

  // Random mix: whole rise-fall-rise measurements with random lengths, some
  // cut short after the high time, and some loose noise.
  task automatic fill_mix(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    logic        p0;
    stop_at = n_gen + n;
    while (n_gen < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        repeat ($urandom_range(1, 8)) begin
          offer(($urandom_range(0, 5) == 0) ? MODE_ARM : MODE_TICK,
                1'($urandom_range(0, 1)), 1);
        end
      end else begin
        p0 = 1'($urandom_range(0, 1));
        offer(MODE_ARM, p0, 1);
        offer(MODE_TICK, 1'b0, $urandom_range(0, 3) + p0);
        offer(MODE_TICK, 1'b1, pulse_len());
        if (pick != 2) begin
          offer(MODE_TICK, 1'b0, pulse_len());
          offer(MODE_TICK, 1'b1, 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0));
        end
      end
    end
  endtask

  // Wait until everything is accepted and every reading is back, then pause.
  task automatic settle();
    while (pin_samples_q.size() != 0 || in_valid_i || readings_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Bring the block back to idle: toggle the pin until a reading ends the
  // measurement that is still armed.
  task automatic quiesce();
    settle();
    while (pw_armed) begin
      offer(MODE_TICK, !pw_prev_pin, 1);
      settle();
    end
  endtask

  task automatic write_timeout(input logic [31:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pw_timeout  = v;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Ticks while idle give nothing.
    offer(MODE_TICK, 1'b1, 1);
    offer(MODE_TICK, 1'b0, 1);
    // Arm with the pin already high: the level at arming is no rise, the
    // fall in the first phase is ignored, shortest possible period follows.
    offer(MODE_ARM, 1'b1, 1);
    offer(MODE_TICK, 1'b1, 1);
    offer(MODE_TICK, 1'b0, 1);
    offer(MODE_TICK, 1'b1, 1);
    offer(MODE_TICK, 1'b0, 1);
    offer(MODE_TICK, 1'b1, 1);
    // Re-arm in the middle of a measurement.
    offer(MODE_ARM, 1'b0, 1);
    offer(MODE_TICK, 1'b1, 1);
    offer(MODE_ARM, 1'b0, 1);
    offer(MODE_TICK, 1'b0, 1);
    offer(MODE_TICK, 1'b1, 2);
    offer(MODE_TICK, 1'b0, 3);
    offer(MODE_TICK, 1'b1, 1);
    fill_mix(300);
    quiesce();

    // Zero timeout: the first armed tick that does not finish times out,
    // duty follows the pin.
    write_timeout('0);
    offer(MODE_ARM, 1'b0, 1);
    offer(MODE_TICK, 1'b1, 1);
    offer(MODE_ARM, 1'b1, 1);
    offer(MODE_TICK, 1'b0, 1);
    // Readings come every few items here: hold the receiver off long
    // enough for the block to back up into its input.
    hold_arm <= 1'b1;
    repeat (150) begin
      offer(MODE_ARM, 1'($urandom_range(0, 1)), 1);
      repeat ($urandom_range(1, 3)) offer(MODE_TICK, 1'($urandom_range(0, 1)), 1);
    end
    quiesce();

    write_timeout(32'd1);
    fill_mix(200);
    quiesce();
    write_timeout(32'd5);
    fill_mix(250);
    quiesce();
    write_timeout(32'd40);
    fill_mix(250);
    quiesce();

    // Largest timeout: long pulses finish as measurements, never time out.
    write_timeout('1);
    fill_mix(200);
    quiesce();

    // Last part runs at full rate on both sides.
    write_timeout(32'd12);
    idle_en <= 1'b0;
    fill_mix(250);
    settle();

    $display("covered %0d items in, readings: %0d measured, %0d timed out, %0d zero period",
             n_items, n_measured, n_timeout, n_fault);
    $display("input stalled by the block in %0d cycles, %0d mismatches",
             n_in_stall, n_mismatch);
    if (n_mismatch == 0) begin
      $display("pwm_input_period_duty_measure_tb OK");
    end else begin
      $display("pwm_input_period_duty_measure_tb NOT OK");
    end
    $finish;
  end

endmodule
